// ===== src/sgrb_pkg.sv =====
// Shared types and constants for the scaled glyph row blitter.
// Used by the controller, the datapath and the top level; no dependencies.
package sgrb_pkg;

    localparam int GLYPH_W     = 8;
    localparam int GLYPH_COUNT = 256;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int COL_IDX_W   = 3;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 16'hFFFF;

    // controller -> datapath
    typedef struct packed {
        logic ram_we;
        logic capture;
        logic load_bits;
        logic emit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_load;
        logic row_ok;
        logic scale_ok;
        logic bits_zero;
        logic last_pix;
        logic out_free;
    } t_status;

endpackage

// ===== src/sgrb_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module sgrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 3072
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sgrb_ctrl.sv =====
// Controller for the scaled glyph row blitter: accepts words, sequences the
// font store read and the pixel write run. Depends on sgrb_pkg.
module sgrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sgrb_pkg::t_status i_status,
    output sgrb_pkg::t_cmd    o_cmd
);
    import sgrb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.ram_we  = accept && i_status.is_load && i_status.row_ok;
                o_cmd.capture = accept && !i_status.is_load && i_status.row_ok
                                && i_status.scale_ok;
                if (o_cmd.capture) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.load_bits = 1'b1;
                n_state = i_status.bits_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                // advance only when the output register can take a word
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free && i_status.last_pix) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/sgrb_dp.sv =====
// Datapath for the scaled glyph row blitter: font store, coordinate
// arithmetic, column walk and output register. Depends on sgrb_pkg, sgrb_ram.
module sgrb_dp #(
    parameter int GLYPH_COLS = 8,
    parameter int GLYPH_ROWS = 12,
    parameter int CHAR_PITCH = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sgrb_pkg::t_cmd                i_cmd,
    output sgrb_pkg::t_status             o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [sgrb_pkg::COLOR_W-1:0]  i_cfg_wr_data,
    input  logic                          i_mode,
    input  logic [7:0]                    i_char_code,
    input  logic [3:0]                    i_row_index,
    input  logic [7:0]                    i_char_position,
    input  logic [8:0]                    i_base_x,
    input  logic [8:0]                    i_base_y,
    input  logic [1:0]                    i_scale,
    input  logic [sgrb_pkg::GLYPH_W-1:0]  i_glyph_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sgrb_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [sgrb_pkg::COORD_W-1:0]  o_pixel_y,
    output logic [sgrb_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                          o_last_pixel
);
    import sgrb_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KSTEP = CHAR_PITCH - 2;
    localparam logic [GLYPH_W-1:0] COL_MASK =
        GLYPH_W'((9'd1 << GLYPH_COLS) - 9'd1);

    logic [AW-1:0]        ram_addr;
    logic [GLYPH_W-1:0]   ram_rdata;
    logic [GLYPH_W-1:0]   masked;
    logic                 in_s2;
    logic [COORD_W-1:0]   xs;
    logic [COORD_W-1:0]   n_xbase;
    logic [COORD_W-1:0]   n_ybase;

    logic [COLOR_W-1:0]   r_color;
    logic [COORD_W-1:0]   r_xbase;
    logic [COORD_W-1:0]   r_ybase;
    logic                 r_s2;
    logic [GLYPH_W-1:0]   r_bits;
    logic                 r_dx;
    logic                 r_dy;

    logic [COL_IDX_W-1:0] col;
    logic [GLYPH_W-1:0]   bits_rest;
    logic                 blk_end;
    logic [COORD_W-1:0]   col_off;
    logic [COORD_W-1:0]   tx;

    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_px;
    logic [COORD_W-1:0]   r_py;
    logic [COLOR_W-1:0]   r_pcol;
    logic                 r_plast;

    assign ram_addr = AW'(AW'(i_char_code) * AW'(GLYPH_ROWS)) + AW'(i_row_index);

    sgrb_ram #(
        .WIDTH (GLYPH_W),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_glyph_bits),
        .o_rdata (ram_rdata)
    );

    // scale three behaves as two
    assign in_s2   = i_scale[1];
    assign xs      = COORD_W'(COORD_W'(i_char_position) * COORD_W'(KSTEP))
                     + COORD_W'(GLYPH_COLS);
    assign n_xbase = (in_s2 ? {xs[COORD_W-2:0], 1'b0} : xs) + COORD_W'(i_base_x);
    assign n_ybase = (in_s2 ? COORD_W'({i_row_index, 1'b0}) : COORD_W'(i_row_index))
                     + COORD_W'(i_base_y);

    assign masked = ram_rdata & COL_MASK;

    // lowest remaining set column
    always_comb begin
        col = '0;
        for (int c = GLYPH_W - 1; c >= 0; c--) begin
            if (r_bits[c]) begin
                col = COL_IDX_W'(c);
            end
        end
    end

    assign bits_rest = r_bits & (r_bits - GLYPH_W'(1));
    assign blk_end   = (r_dx == r_s2) && (r_dy == r_s2);
    assign col_off   = r_s2 ? COORD_W'({col, 1'b0}) : COORD_W'(col);
    assign tx        = r_xbase - col_off;

    always_comb begin
        o_status           = '0;
        o_status.is_load   = i_mode;
        o_status.row_ok    = ({1'b0, i_row_index} < 5'(GLYPH_ROWS));
        o_status.scale_ok  = (i_scale != 2'd0);
        o_status.bits_zero = (masked == '0);
        o_status.last_pix  = blk_end && (bits_rest == '0);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_xbase <= n_xbase;
            r_ybase <= n_ybase;
            r_s2    <= in_s2;
        end
        if (i_cmd.load_bits) begin
            r_bits <= masked;
            r_dx   <= 1'b0;
            r_dy   <= 1'b0;
        end else if (i_cmd.emit) begin
            // dx inner, dy outer; drop the column after its last block write
            if (r_dx != r_s2) begin
                r_dx <= 1'b1;
            end else begin
                r_dx <= 1'b0;
                if (r_dy != r_s2) begin
                    r_dy <= 1'b1;
                end else begin
                    r_dy   <= 1'b0;
                    r_bits <= bits_rest;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px    <= tx + COORD_W'(r_dx);
            r_py    <= r_ybase + COORD_W'(r_dy);
            r_pcol  <= r_color;
            r_plast <= o_status.last_pix;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcol;
    assign o_last_pixel  = r_plast;

endmodule

// ===== src/scaled_glyph_row_blitter.sv =====
// Scaled glyph row blitter: top level joining controller and datapath.
// Depends on sgrb_pkg, sgrb_ctrl, sgrb_dp (and sgrb_ram below it).
//
// A load word writes one font row into the store in the cycle it is taken
// and never stalls the input. A draw word is accepted, its font row is read
// from the registered font store, then one pixel write is made per cycle
// while the output does not stall: four for each set column at scale two or
// three, one at scale one, up to 32 for a scale-2 row of eight columns. The
// single font store port and the one-write-per-cycle output register set
// the pace of a draw. Only one word is in work at a time; the next is taken
// while the final pixel write still waits in the output register.
// Rows beyond the font height, scale zero and empty rows give no writes.
module scaled_glyph_row_blitter #(
    parameter int GLYPH_COLS = 8,
    parameter int GLYPH_ROWS = 12,
    parameter int CHAR_PITCH = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [sgrb_pkg::COLOR_W-1:0]  i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [7:0]                    i_char_code,
    input  logic [3:0]                    i_row_index,
    input  logic [7:0]                    i_char_position,
    input  logic [8:0]                    i_base_x,
    input  logic [8:0]                    i_base_y,
    input  logic [1:0]                    i_scale,
    input  logic [sgrb_pkg::GLYPH_W-1:0]  i_glyph_bits,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sgrb_pkg::COORD_W-1:0]  o_pixel_x,
    output logic [sgrb_pkg::COORD_W-1:0]  o_pixel_y,
    output logic [sgrb_pkg::COLOR_W-1:0]  o_pixel_color,
    output logic                          o_last_pixel
);
    import sgrb_pkg::*;

    t_cmd    cmd;
    t_status status;

    sgrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sgrb_dp #(
        .GLYPH_COLS (GLYPH_COLS),
        .GLYPH_ROWS (GLYPH_ROWS),
        .CHAR_PITCH (CHAR_PITCH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_mode          (i_mode),
        .i_char_code     (i_char_code),
        .i_row_index     (i_row_index),
        .i_char_position (i_char_position),
        .i_base_x        (i_base_x),
        .i_base_y        (i_base_y),
        .i_scale         (i_scale),
        .i_glyph_bits    (i_glyph_bits),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_color   (o_pixel_color),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
